>>> sv/gamepad_change_event_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// Gamepad change event encoder - assertion macros
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_CHANGE_EVENT_ENCODER_CORE_DEFINES_SVH
`define GAMEPAD_CHANGE_EVENT_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define GCEE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GCEE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GCEE_ASSERT_IMP(lbl, ante, cons, msg)
`define GCEE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/gcee_pkg.sv
// ----------------------------------------------------------------------------
// gcee_pkg
// Types, codes and constants shared by the gamepad change event encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gcee_pkg;

    localparam int AXIS_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int RAW_W       = 16;
    localparam int VALUE_W     = 17;
    localparam int NUM_BUTTONS = 10;
    localparam int NUM_AXES    = 5;
    localparam int NUM_SLOTS   = 14;

    // slot positions in the event mask after the ten buttons
    localparam int SLOT_HAT    = 10;
    localparam int SLOT_LSTICK = 11;
    localparam int SLOT_RSTICK = 12;
    localparam int SLOT_TRIG   = 13;

    // axis order in the stored sample
    localparam int AX_LX = 0;
    localparam int AX_LY = 1;
    localparam int AX_RX = 2;
    localparam int AX_RY = 3;
    localparam int AX_TR = 4;

    localparam logic [15:0] HAT_CENTER = 16'hFFFF;
    localparam logic [15:0] HAT_UP     = 16'h0000;
    localparam logic [15:0] HAT_LEFT   = 16'h6978;
    localparam logic [15:0] HAT_DOWN   = 16'h4650;
    localparam logic [15:0] HAT_RIGHT  = 16'h2328;

    // hat ids follow the buttons: id = base + direction code
    localparam logic [3:0] HAT_ID_BASE = 4'd9;

    // button id -> bit of the buttons field
    localparam logic [3:0] BTN_BIT [NUM_BUTTONS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd8, 4'd9, 4'd7, 4'd6
    };

    typedef enum logic [2:0] {
        KIND_PRESS   = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_LSTICK  = 3'd2,
        KIND_RSTICK  = 3'd3,
        KIND_TRIG    = 3'd4
    } evt_kind_t;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_DOWN  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    typedef enum logic {
        REG_CAPTURE = 1'b0,
        REG_EVENTS  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic capture_enabled;
        logic events_enabled;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // one classified sample waiting for the back end
    typedef struct packed {
        logic [NUM_SLOTS-1:0]                mask;
        logic [NUM_BUTTONS-1:0]              btn_press;
        logic [3:0]                          hat_id;
        logic                                hat_release;
        logic [NUM_AXES-1:0][VALUE_W-1:0]    val;
    } evt_rec_t;

endpackage

`default_nettype wire

>>> sv/gcee_fifo.sv
// ----------------------------------------------------------------------------
// gcee_fifo
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module gcee_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic                  rd_en,
    output logic      [WIDTH-1:0]      rd_data,
    output gcee_pkg::q_status_t        status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/gcee_front.sv
// ----------------------------------------------------------------------------
// gcee_front
// Accepts samples, compares them with the stored sample and builds the event
// record for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gcee_front #(
    parameter int AXIS_BITS = gcee_pkg::AXIS_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gcee_pkg::cfg_t                      cfg,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [gcee_pkg::NUM_BUTTONS-1:0]    buttons,
    input  wire logic [gcee_pkg::RAW_W-1:0]          hat_angle,
    input  wire logic [gcee_pkg::RAW_W-1:0]          left_x,
    input  wire logic [gcee_pkg::RAW_W-1:0]          left_y,
    input  wire logic [gcee_pkg::RAW_W-1:0]          right_x,
    input  wire logic [gcee_pkg::RAW_W-1:0]          right_y,
    input  wire logic [gcee_pkg::RAW_W-1:0]          trigger_axis,
    input  wire gcee_pkg::q_status_t                 q_status,
    output logic                                     q_push,
    output gcee_pkg::evt_rec_t                       q_rec
);

    localparam logic [AXIS_BITS-1:0] AXIS_CENTER = AXIS_BITS'((1 << (AXIS_BITS - 1)) - 1);
    localparam logic [gcee_pkg::VALUE_W-1:0] CENTER_EXT =
        gcee_pkg::VALUE_W'((1 << (AXIS_BITS - 1)) - 1);

    logic [gcee_pkg::NUM_BUTTONS-1:0] prev_buttons_reg;
    gcee_pkg::dir_t                   prev_dir_reg, dir_next;
    logic [AXIS_BITS-1:0]             prev_axes_reg [gcee_pkg::NUM_AXES];
    logic [AXIS_BITS-1:0]             ax [gcee_pkg::NUM_AXES];
    logic [gcee_pkg::NUM_AXES-1:0]    ax_chg;
    logic                             accept, capture;

    assign full    = q_status.full;
    assign accept  = push && !full;
    assign capture = accept && cfg.capture_enabled;

    assign ax[gcee_pkg::AX_LX] = left_x[AXIS_BITS-1:0];
    assign ax[gcee_pkg::AX_LY] = left_y[AXIS_BITS-1:0];
    assign ax[gcee_pkg::AX_RX] = right_x[AXIS_BITS-1:0];
    assign ax[gcee_pkg::AX_RY] = right_y[AXIS_BITS-1:0];
    assign ax[gcee_pkg::AX_TR] = trigger_axis[AXIS_BITS-1:0];

    // decode the hat; unlisted angles keep the old direction
    always_comb
    begin
        unique case (hat_angle)
            gcee_pkg::HAT_CENTER: dir_next = gcee_pkg::DIR_NONE;
            gcee_pkg::HAT_UP:     dir_next = gcee_pkg::DIR_UP;
            gcee_pkg::HAT_LEFT:   dir_next = gcee_pkg::DIR_LEFT;
            gcee_pkg::HAT_DOWN:   dir_next = gcee_pkg::DIR_DOWN;
            gcee_pkg::HAT_RIGHT:  dir_next = gcee_pkg::DIR_RIGHT;
            default:              dir_next = prev_dir_reg;
        endcase
    end

    always_comb
    begin
        q_rec = '0;
        for (int i = 0; i < gcee_pkg::NUM_BUTTONS; i++)
        begin
            q_rec.mask[i]      = buttons[gcee_pkg::BTN_BIT[i]]
                                 != prev_buttons_reg[gcee_pkg::BTN_BIT[i]];
            q_rec.btn_press[i] = buttons[gcee_pkg::BTN_BIT[i]];
        end

        // a new direction only presses; going to center releases the old one
        q_rec.mask[gcee_pkg::SLOT_HAT] = (dir_next != prev_dir_reg);
        q_rec.hat_release = (dir_next == gcee_pkg::DIR_NONE);
        q_rec.hat_id = gcee_pkg::HAT_ID_BASE
                       + {1'b0, (q_rec.hat_release ? prev_dir_reg : dir_next)};

        for (int i = 0; i < gcee_pkg::NUM_AXES; i++)
        begin
            ax_chg[i]   = (ax[i] != prev_axes_reg[i]);
            q_rec.val[i] = {{(gcee_pkg::VALUE_W - AXIS_BITS){1'b0}}, ax[i]} - CENTER_EXT;
        end
        q_rec.mask[gcee_pkg::SLOT_LSTICK] = ax_chg[gcee_pkg::AX_LX] || ax_chg[gcee_pkg::AX_LY];
        q_rec.mask[gcee_pkg::SLOT_RSTICK] = ax_chg[gcee_pkg::AX_RX] || ax_chg[gcee_pkg::AX_RY];
        q_rec.mask[gcee_pkg::SLOT_TRIG]   = ax_chg[gcee_pkg::AX_TR];
    end

    assign q_push = capture && cfg.events_enabled && (q_rec.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= '0;
            prev_dir_reg     <= gcee_pkg::DIR_NONE;
            for (int i = 0; i < gcee_pkg::NUM_AXES; i++)
            begin
                prev_axes_reg[i] <= AXIS_CENTER;
            end
        end
        else if (capture)
        begin
            prev_buttons_reg <= buttons;
            prev_dir_reg     <= dir_next;
            for (int i = 0; i < gcee_pkg::NUM_AXES; i++)
            begin
                prev_axes_reg[i] <= ax[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/gcee_back.sv
// ----------------------------------------------------------------------------
// gcee_back
// Walks the event mask of each queued record, lowest slot first, and emits
// one event per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gamepad_change_event_encoder_core_defines.svh"

module gcee_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gcee_pkg::q_status_t                 q_status,
    input  wire gcee_pkg::evt_rec_t                  q_rec,
    output logic                                     q_pop,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [2:0]                               event_kind,
    output logic [3:0]                               button_id,
    output logic signed [gcee_pkg::VALUE_W-1:0]      value_x,
    output logic signed [gcee_pkg::VALUE_W-1:0]      value_y,
    output logic                                     last
);

    localparam int SLOT_W = $clog2(gcee_pkg::NUM_SLOTS);

    gcee_pkg::evt_rec_t             cur_reg;
    logic                           cur_valid_reg, cur_valid_next;
    logic [gcee_pkg::NUM_SLOTS-1:0] cur_mask_reg, cur_mask_next;
    logic [gcee_pkg::NUM_SLOTS-1:0] low_bit, remaining;
    logic [SLOT_W-1:0]              slot;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_free, advance, emit_last;

    gcee_pkg::evt_kind_t            kind_sel;
    logic [3:0]                     id_sel;
    logic [gcee_pkg::VALUE_W-1:0]   vx_sel, vy_sel;

    assign out_free  = !out_valid_reg || pop;
    assign advance   = cur_valid_reg && out_free;
    assign low_bit   = cur_mask_reg & (~cur_mask_reg + 1'b1);
    assign remaining = cur_mask_reg & ~low_bit;
    assign emit_last = (remaining == '0);
    assign q_pop     = !q_status.empty && (!cur_valid_reg || (advance && emit_last));

    always_comb
    begin
        slot = '0;
        for (int i = 0; i < gcee_pkg::NUM_SLOTS; i++)
        begin
            if (low_bit[i])
            begin
                slot = slot | SLOT_W'(i);
            end
        end
    end

    // map the chosen slot to its event fields
    always_comb
    begin
        kind_sel = gcee_pkg::KIND_PRESS;
        id_sel   = '0;
        vx_sel   = '0;
        vy_sel   = '0;
        case (slot)
            SLOT_W'(gcee_pkg::SLOT_HAT):
            begin
                kind_sel = cur_reg.hat_release ? gcee_pkg::KIND_RELEASE : gcee_pkg::KIND_PRESS;
                id_sel   = cur_reg.hat_id;
            end
            SLOT_W'(gcee_pkg::SLOT_LSTICK):
            begin
                kind_sel = gcee_pkg::KIND_LSTICK;
                vx_sel   = cur_reg.val[gcee_pkg::AX_LX];
                vy_sel   = cur_reg.val[gcee_pkg::AX_LY];
            end
            SLOT_W'(gcee_pkg::SLOT_RSTICK):
            begin
                kind_sel = gcee_pkg::KIND_RSTICK;
                vx_sel   = cur_reg.val[gcee_pkg::AX_RX];
                vy_sel   = cur_reg.val[gcee_pkg::AX_RY];
            end
            SLOT_W'(gcee_pkg::SLOT_TRIG):
            begin
                kind_sel = gcee_pkg::KIND_TRIG;
                vx_sel   = cur_reg.val[gcee_pkg::AX_TR];
            end
            default:
            begin
                if (slot < SLOT_W'(gcee_pkg::NUM_BUTTONS))
                begin
                    kind_sel = cur_reg.btn_press[slot] ? gcee_pkg::KIND_PRESS
                                                       : gcee_pkg::KIND_RELEASE;
                    id_sel   = 4'(slot);
                end
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_mask_next  = cur_mask_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_mask_next  = q_rec.mask;
        end
        else if (advance)
        begin
            cur_valid_next = !emit_last;
            cur_mask_next  = remaining;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_mask_reg  <= cur_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_rec;
        end
        if (advance)
        begin
            event_kind <= kind_sel;
            button_id  <= id_sel;
            value_x    <= vx_sel;
            value_y    <= vy_sel;
            last       <= emit_last;
        end
    end

    assign empty = !out_valid_reg;

    `GCEE_ASSERT_IMP(a_cur_mask_live, cur_valid_reg, cur_mask_reg != '0, "active record has no events left")
    `GCEE_ASSERT_IMP(a_pop_nonempty, q_pop, !q_status.empty, "queue read while empty")
    `GCEE_ASSERT_NXT(a_keep_record, advance && !emit_last, cur_valid_reg, "record dropped before its last event")
    `GCEE_ASSERT_NXT(a_out_loaded, advance, !empty, "emitted event not presented")

endmodule

`default_nettype wire

>>> sv/gamepad_change_event_encoder_core.sv
// ----------------------------------------------------------------------------
// gamepad_change_event_encoder_core
// Compares each gamepad sample with the last one and emits button, hat,
// stick and trigger change events.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  sample    push / full                buttons, hat_angle, left_x .. trigger_axis
//  event     empty / pop                event_kind, button_id, value_x, value_y, last
//  config    psel penable pwrite pready paddr, pwdata, prdata
//
//  With capture enabled, the front end updates the stored sample at the edge a
//  sample is accepted, and with events enabled and any change it queues its event
//  record (QUEUE_DEPTH entries). The back end emits one event per cycle while
//  its output register is empty or popped; each record moves from the queue
//  via cur_reg to the output register. full rises only when the queue is full.
//  Reset clears the stored sample to centered axes and released buttons.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_change_event_encoder_core #(
    parameter int AXIS_BITS   = gcee_pkg::AXIS_BITS_DEF,
    parameter int QUEUE_DEPTH = gcee_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [gcee_pkg::NUM_BUTTONS-1:0]    buttons,
    input  wire logic [gcee_pkg::RAW_W-1:0]          hat_angle,
    input  wire logic [gcee_pkg::RAW_W-1:0]          left_x,
    input  wire logic [gcee_pkg::RAW_W-1:0]          left_y,
    input  wire logic [gcee_pkg::RAW_W-1:0]          right_x,
    input  wire logic [gcee_pkg::RAW_W-1:0]          right_y,
    input  wire logic [gcee_pkg::RAW_W-1:0]          trigger_axis,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [2:0]                               event_kind,
    output logic [3:0]                               button_id,
    output logic signed [gcee_pkg::VALUE_W-1:0]      value_x,
    output logic signed [gcee_pkg::VALUE_W-1:0]      value_y,
    output logic                                     last
);

    gcee_pkg::cfg_t      cfg_reg;
    gcee_pkg::q_status_t q_status;
    gcee_pkg::evt_rec_t  q_wr_rec, q_rd_rec;
    logic                q_push, q_pop, cfg_wr;
    gcee_pkg::reg_idx_t  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = gcee_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                gcee_pkg::REG_CAPTURE: cfg_reg.capture_enabled <= pwdata[0];
                gcee_pkg::REG_EVENTS:  cfg_reg.events_enabled  <= pwdata[0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gcee_pkg::REG_CAPTURE: prdata = {31'b0, cfg_reg.capture_enabled};
            gcee_pkg::REG_EVENTS:  prdata = {31'b0, cfg_reg.events_enabled};
            default:               prdata = '0;
        endcase
    end

    gcee_front #(
        .AXIS_BITS (AXIS_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .full         (full),
        .buttons      (buttons),
        .hat_angle    (hat_angle),
        .left_x       (left_x),
        .left_y       (left_y),
        .right_x      (right_x),
        .right_y      (right_y),
        .trigger_axis (trigger_axis),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_rec        (q_wr_rec)
    );

    gcee_fifo #(
        .WIDTH ($bits(gcee_pkg::evt_rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_rec),
        .rd_en   (q_pop),
        .rd_data (q_rd_rec),
        .status  (q_status)
    );

    gcee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_rec      (q_rd_rec),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .event_kind (event_kind),
        .button_id  (button_id),
        .value_x    (value_x),
        .value_y    (value_y),
        .last       (last)
    );

endmodule

`default_nettype wire
